// ----- src/assert_macros.svh -----
// assertion macros for the euler angle block
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rmte_pkg.sv -----
// shared types, constants and the arctangent table for the euler angle block
// no dependencies
package rmte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int IN_W    = 25;   // scaled atan2 inputs
    localparam int CW      = 28;   // cordic x and y
    localparam int ZW      = 26;   // angle accumulator, degrees times 65536
    localparam int SQ_W    = 48;
    localparam int ROOT_W  = 24;
    localparam int SQRT_LAT = ROOT_W + 2;

    localparam logic signed [ZW-1:0] DEG180_FINE = ZW'(11796480);
    localparam logic signed [ZW-1:0] DEG90_FINE  = ZW'(5898240);
    localparam logic signed [16:0] HALF_TURN = 17'sd23040;
    localparam logic signed [16:0] FULL_TURN = 17'sd46080;
    localparam logic signed [16:0] PITCH_LIM = 17'sd11520;

    typedef struct packed {
        logic        singular;
        logic [15:0] yaw_second;
        logic [15:0] pitch_second;
        logic [15:0] roll_second;
        logic [15:0] yaw_first;
        logic [14:0] pitch_first;
        logic [15:0] roll_first;
    } rmte_res_t;

    function automatic logic [ZW-1:0] atan_fine(input int i);
        logic [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58670);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/rotation_matrix_to_euler_angles.sv -----
// top level: zyx euler angles, both solutions, from five rotation matrix elements
// depends on rmte_pkg, rmte_sqrt, rmte_cordic and assert_macros.svh
//
// Takes one matrix per clock cycle while s_axis_tready is high. An accepted input
// transaction passes a 26-stage square-and-root pipeline for the pitch magnitude,
// an unrolled cordic of CORDIC_STEPS stages (CORDIC_STEPS is capped at 24 in the
// arithmetic) plus an entry and a rounding stage, and one stage that forms the
// second pitch. The whole pipeline advances together; a two-entry output buffer
// keeps the input side moving while one result waits. Angles are degrees times 128
// in [-180, 180); singular is set when row2_col1 and row2_col2 are both zero, and
// roll and yaw are then forced to zero.
`include "assert_macros.svh"

module rotation_matrix_to_euler_angles
    import rmte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row0_col0, row1_col0, row2_col0, row2_col1, row2_col2
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_first, pitch_first, yaw_first, roll_second, pitch_second, yaw_second, pad
    output logic [95:0]  m_axis_tdata,
    // singular
    output logic         m_axis_tuser
);

    localparam int N   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int SD  = N + 2;
    localparam int LAT = SQRT_LAT + N + 3;

    logic                 en, push, pop;
    logic [LAT-1:0]       vld_reg;
    logic [79:0]          in_dly_reg [0:SQRT_LAT-1];
    logic [1:0]           side_reg   [0:SD-1];
    logic [ROOT_W-1:0]    root;
    logic signed [15:0]   r00, r10, r20, r21, r22;
    logic                 sing_now;
    logic signed [15:0]   pitch_a, roll1_a, roll2_a, yaw1_a, yaw2_a;
    logic signed [16:0]   p1c, p2raw, p2w;
    rmte_res_t            res_next, res_reg, head_reg, skid_reg;
    logic                 head_v_reg, skid_v_reg;

    function automatic logic signed [IN_W-1:0] scl(input logic signed [15:0] v);
        return {v[15], v, 8'b0};
    endfunction

    assign pop           = head_v_reg && m_axis_tready;
    assign en            = !skid_v_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign push          = en && vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_dly_reg[0] <= s_axis_tdata;
            for (int k = 1; k < SQRT_LAT; k++)
                in_dly_reg[k] <= in_dly_reg[k-1];
            side_reg[0] <= {(r20 <= 0), sing_now};
            for (int k = 1; k < SD; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    rmte_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .a    (s_axis_tdata[63:48]),
        .b    (s_axis_tdata[79:64]),
        .root (root)
    );

    assign r00 = in_dly_reg[SQRT_LAT-1][15:0];
    assign r10 = in_dly_reg[SQRT_LAT-1][31:16];
    assign r20 = in_dly_reg[SQRT_LAT-1][47:32];
    assign r21 = in_dly_reg[SQRT_LAT-1][63:48];
    assign r22 = in_dly_reg[SQRT_LAT-1][79:64];
    assign sing_now = (r21 == 0) && (r22 == 0);

    rmte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .en(en), .y_in(-scl(r20)), .x_in({1'b0, root}), .angle(pitch_a)
    );
    rmte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll1 (
        .clk(clk), .en(en), .y_in(scl(r21)), .x_in(scl(r22)), .angle(roll1_a)
    );
    rmte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll2 (
        .clk(clk), .en(en), .y_in(-scl(r21)), .x_in(-scl(r22)), .angle(roll2_a)
    );
    rmte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw1 (
        .clk(clk), .en(en), .y_in(scl(r10)), .x_in(scl(r00)), .angle(yaw1_a)
    );
    rmte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw2 (
        .clk(clk), .en(en), .y_in(-scl(r10)), .x_in(-scl(r00)), .angle(yaw2_a)
    );

    always_comb
    begin
        p1c = {pitch_a[15], pitch_a};
        if (p1c > PITCH_LIM)
            p1c = PITCH_LIM;
        else if (p1c < -PITCH_LIM)
            p1c = -PITCH_LIM;
        p2raw = (side_reg[SD-1][1] ? HALF_TURN : -HALF_TURN) - p1c;
        p2w   = p2raw;
        if (p2raw >= HALF_TURN)
            p2w = p2raw - FULL_TURN;
        else if (p2raw < -HALF_TURN)
            p2w = p2raw + FULL_TURN;
        res_next.singular     = side_reg[SD-1][0];
        res_next.pitch_first  = p1c[14:0];
        res_next.pitch_second = p2w[15:0];
        res_next.roll_first   = side_reg[SD-1][0] ? '0 : roll1_a;
        res_next.roll_second  = side_reg[SD-1][0] ? '0 : roll2_a;
        res_next.yaw_first    = side_reg[SD-1][0] ? '0 : yaw1_a;
        res_next.yaw_second   = side_reg[SD-1][0] ? '0 : yaw2_a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            head_v_reg <= skid_v_reg || push;
            skid_v_reg <= skid_v_reg && push;
        end
        else if (push)
        begin
            head_v_reg <= 1'b1;
            skid_v_reg <= head_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg <= skid_v_reg ? skid_reg : res_reg;
            if (skid_v_reg && push)
                skid_reg <= res_reg;
        end
        else if (push)
        begin
            if (head_v_reg)
                skid_reg <= res_reg;
            else
                head_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = head_v_reg;
    assign m_axis_tuser  = head_reg.singular;
    assign m_axis_tdata  = {1'b0, head_reg.yaw_second, head_reg.pitch_second,
                            head_reg.roll_second, head_reg.yaw_first,
                            head_reg.pitch_first, head_reg.roll_first};

    `ASSERT_CLK(a_skid_needs_head, skid_v_reg |-> head_v_reg, "skid entry without head entry")
    `ASSERT_CLK(a_no_overflow, !(push && skid_v_reg && !pop), "result pushed into full buffer")
    `ASSERT_NEXT(a_accept_tracked, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted transaction lost")
    `ASSERT_CLK(a_singular_zero, (head_v_reg && head_reg.singular) |-> (head_reg.roll_first == '0 && head_reg.yaw_first == '0 && head_reg.roll_second == '0 && head_reg.yaw_second == '0), "singular result with nonzero roll or yaw")
    `ASSERT_CLK(a_pitch_range, head_v_reg |-> ($signed(head_reg.pitch_first) <= 15'sd11520 && $signed(head_reg.pitch_first) >= -15'sd11520), "first pitch out of range")

endmodule

// ----- src/rmte_sqrt.sv -----
// pipelined magnitude of the third-row tail: floor(sqrt((a^2 + b^2) * 65536))
// depends on rmte_pkg
module rmte_sqrt
    import rmte_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [15:0]       a,
    input  logic signed [15:0]       b,
    output logic [ROOT_W-1:0]        root
);

    logic signed [31:0] pa_reg, pb_reg;
    logic [SQ_W-1:0]    rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]  root_reg [0:ROOT_W];
    logic [31:0]        sq;

    assign sq = 32'(pa_reg) + 32'(pb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg      <= a * a;
            pb_reg      <= b * b;
            rem_reg[0]  <= {sq, 16'b0};
            root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_bit
        localparam int K = ROOT_W - 1 - j;
        logic [SQ_W-1:0] cmp;
        assign cmp = ({{(SQ_W-ROOT_W){1'b0}}, root_reg[j]} << (K + 1))
                   + ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * K));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j] >= cmp)
                begin
                    rem_reg[j+1]  <= rem_reg[j] - cmp;
                    root_reg[j+1] <= root_reg[j] | ({{(ROOT_W-1){1'b0}}, 1'b1} << K);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
            end
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

// ----- src/rmte_cordic.sv -----
// unrolled vectoring cordic atan2 with axis cases, rounding to q8.7 and wrap
// depends on rmte_pkg
module rmte_cordic
    import rmte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [IN_W-1:0]  y_in,
    input  logic signed [IN_W-1:0]  x_in,
    output logic signed [15:0]      angle
);

    localparam int N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 fix_reg [0:N];
    logic signed [15:0]   angle_reg;

    logic signed [CW-1:0] xe, ye;
    logic signed [ZW-1:0] zr;
    logic signed [16:0]   q, qw;

    assign xe = {{(CW-IN_W){x_in[IN_W-1]}}, x_in};
    assign ye = {{(CW-IN_W){y_in[IN_W-1]}}, y_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= xe;
            y_reg[0]   <= ye;
            z_reg[0]   <= '0;
            fix_reg[0] <= 1'b0;
            if (y_in == '0)
            begin
                fix_reg[0] <= 1'b1;
                z_reg[0]   <= (x_in < 0) ? DEG180_FINE : '0;
            end
            else if (x_in == '0)
            begin
                fix_reg[0] <= 1'b1;
                z_reg[0]   <= (y_in > 0) ? DEG90_FINE : -DEG90_FINE;
            end
            else if (x_in < 0)
            begin
                z_reg[0] <= (y_in >= 0) ? DEG180_FINE : -DEG180_FINE;
                x_reg[0] <= -xe;
                y_reg[0] <= -ye;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [ZW-1:0] t;
        assign t = atan_fine(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fix_reg[i+1] <= fix_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= fix_reg[i] ? z_reg[i] : z_reg[i] + t;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= fix_reg[i] ? z_reg[i] : z_reg[i] - t;
                end
            end
        end
    end

    assign zr = z_reg[N] + ZW'(256);
    assign q  = zr[ZW-1:9];

    always_comb
    begin
        qw = q;
        if (q >= HALF_TURN)
            qw = q - FULL_TURN;
        else if (q < -HALF_TURN)
            qw = q + FULL_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= qw[15:0];
    end

    assign angle = angle_reg;

endmodule

// ----- tb/sv/rotation_matrix_to_euler_angles_tb.sv -----
// testbench for rotation_matrix_to_euler_angles: directed table, then random matrices
// depends on rmte_pkg and the block; predicts both zyx solutions with its own cordic
module rotation_matrix_to_euler_angles_tb
    import rmte_pkg::*;
();

    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int RAND_ITEMS = 600;
    localparam int WDOG_LIMIT = 20000;
    localparam longint ANG180 = 64'sd11796480;
    localparam longint ANG90  = 64'sd5898240;

    typedef struct {
        logic [15:0] r00, r10, r20, r21, r22;
        bit          has_exp;
        logic [95:0] exp_data;
        logic        exp_sing;
    } matrix_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [95:0] angles_q[$];
    logic        sing_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit stim_done = 1'b0;
    matrix_row_t dir_rows[$];

    rotation_matrix_to_euler_angles i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan2_fine(input longint y_in, input longint x_in);
        longint x, y, z, nx, ny;
        longint tab[24];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58670, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        x = x_in;
        y = y_in;
        z = 0;
        if (y == 0)
            return (x < 0) ? ANG180 : 0;
        if (x == 0)
            return (y > 0) ? ANG90 : -ANG90;
        if (x < 0)
        begin
            z = (y >= 0) ? ANG180 : -ANG180;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (y > 0)
            begin
                nx = x + shr(y, i);
                ny = y - shr(x, i);
                z += tab[i];
            end
            else
            begin
                nx = x - shr(y, i);
                ny = y + shr(x, i);
                z -= tab[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint wrap_deg(input longint v);
        if (v >= 23040)
            v -= 46080;
        if (v < -23040)
            v += 46080;
        return v;
    endfunction

    function automatic longint fine_to_q87(input longint f);
        return wrap_deg(shr(f + 256, 9));
    endfunction

    function automatic longint root_floor(input longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic euler_predict(input logic [79:0] d, output logic [95:0] ang,
                                 output logic sing);
        longint r00, r10, r20, a21, a22, m, ny, p1, p2, ro1, ro2, y1, y2;
        r00 = longint'($signed(d[15:0])) * 256;
        r10 = longint'($signed(d[31:16])) * 256;
        r20 = longint'($signed(d[47:32])) * 256;
        a21 = longint'($signed(d[63:48]));
        a22 = longint'($signed(d[79:64]));
        m = root_floor((a21 * a21 + a22 * a22) * 65536);
        ny = -r20;
        sing = (a21 == 0 && a22 == 0);
        ro1 = 0; ro2 = 0; y1 = 0; y2 = 0;
        p1 = fine_to_q87(atan2_fine(ny, m));
        if (p1 > 11520) p1 = 11520;
        if (p1 < -11520) p1 = -11520;
        p2 = wrap_deg(((ny >= 0) ? 23040 : -23040) - p1);
        if (!sing)
        begin
            ro1 = fine_to_q87(atan2_fine(a21 * 256, a22 * 256));
            ro2 = fine_to_q87(atan2_fine(-a21 * 256, -a22 * 256));
            y1 = fine_to_q87(atan2_fine(r10, r00));
            y2 = fine_to_q87(atan2_fine(-r10, -r00));
        end
        ang = {1'b0, y2[15:0], p2[15:0], ro2[15:0], y1[15:0], p1[14:0], ro1[15:0]};
    endtask

    function automatic matrix_row_t mrow(input int a, b, c, e, f, input bit he = 0,
                                         input logic [95:0] ed = '0, input logic es = 0);
        matrix_row_t r;
        r.r00 = a[15:0]; r.r10 = b[15:0]; r.r20 = c[15:0];
        r.r21 = e[15:0]; r.r22 = f[15:0];
        r.has_exp = he; r.exp_data = ed; r.exp_sing = es;
        return r;
    endfunction

    // send one transaction, enqueue its prediction; tvalid stays high on return
    task automatic send_matrix(input matrix_row_t r);
        logic [79:0] d;
        logic [95:0] a;
        logic s;
        d = {r.r22, r.r21, r.r20, r.r10, r.r00};
        euler_predict(d, a, s);
        if (r.has_exp)
        begin
            a = r.exp_data;
            s = r.exp_sing;
        end
        while (!calm && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        angles_q.insert(angles_q.size(), a);
        sing_q.insert(sing_q.size(), s);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // expected: all-zero matrix is singular, pitch 0, second pitch -180
    localparam logic [95:0] ZERO_EXP = {1'b0, 16'd0, 16'hA600, 16'd0, 16'd0, 15'd0, 16'd0};
    // -r20 positive, singular: pitch +90, second pitch +90
    localparam logic [95:0] UP_EXP   = {1'b0, 16'd0, 16'd11520, 16'd0, 16'd0,
                                        15'd11520, 16'd0};

    initial
    begin
        logic [15:0] v[5];
        dir_rows = '{
            mrow(0, 0, 0, 0, 0, 1, ZERO_EXP, 1),
            mrow(0, 0, -32768, 0, 0, 1, UP_EXP, 1),
            mrow(0, 0, 32767, 0, 0),
            mrow(32767, 0, 0, 0, 32767),
            mrow(-32768, 0, 0, 0, -32768),
            mrow(0, 32767, 0, 32767, 0),
            mrow(0, -32768, 0, -32768, 0),
            mrow(-32768, -32768, -32768, -32768, -32768),
            mrow(32767, 32767, 32767, 32767, 32767),
            mrow(-32768, 32767, 32767, -32768, 32767),
            mrow(23170, 23170, -23170, 16384, 16384),
            mrow(-1, 1, -1, 1, -1),
            mrow(0, 0, 16384, 0, 0),
            mrow(0, 0, 5, 0, 1),
            mrow(-5, 0, 0, 3, -7),
            mrow(21845, -10922, 0, -1, 0),
            mrow(32767, -1, -32768, 1, 0)
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_matrix(dir_rows[i]);
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= 200 && n < 300);
            if (n == 350)
            begin
                s_axis_tvalid <= 1'b0;
                wait (angles_q.size() == 0);
            end
            for (int k = 0; k < 5; k++)
            begin
                case ($urandom_range(7))
                    0: v[k] = 16'h0000;
                    1: v[k] = 16'h7FFF;
                    2: v[k] = 16'h8000;
                    3: v[k] = 16'($signed($urandom_range(8)) - 4);
                    default: v[k] = 16'($urandom);
                endcase
            end
            if ($urandom_range(15) == 0)
            begin
                v[3] = 16'h0000;
                v[4] = 16'h0000;
            end
            send_matrix(mrow($signed(v[0]), $signed(v[1]), $signed(v[2]),
                             $signed(v[3]), $signed(v[4])));
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angles_q.size() == 0)
            begin
                $display("%0t unexpected transaction %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                logic [95:0] ea;
                logic es;
                ea = angles_q.pop_front();
                es = sing_q.pop_front();
                if (m_axis_tdata[15:0] !== ea[15:0])
                begin
                    $display("%0t roll_first exp %h got %h", $time, ea[15:0], m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[30:16] !== ea[30:16])
                begin
                    $display("%0t pitch_first exp %h got %h", $time, ea[30:16],
                             m_axis_tdata[30:16]);
                    errors++;
                end
                if (m_axis_tdata[46:31] !== ea[46:31])
                begin
                    $display("%0t yaw_first exp %h got %h", $time, ea[46:31], m_axis_tdata[46:31]);
                    errors++;
                end
                if (m_axis_tdata[62:47] !== ea[62:47])
                begin
                    $display("%0t roll_second exp %h got %h", $time, ea[62:47],
                             m_axis_tdata[62:47]);
                    errors++;
                end
                if (m_axis_tdata[78:63] !== ea[78:63])
                begin
                    $display("%0t pitch_second exp %h got %h", $time, ea[78:63],
                             m_axis_tdata[78:63]);
                    errors++;
                end
                if (m_axis_tdata[94:79] !== ea[94:79])
                begin
                    $display("%0t yaw_second exp %h got %h", $time, ea[94:79],
                             m_axis_tdata[94:79]);
                    errors++;
                end
                if (m_axis_tuser !== es)
                begin
                    $display("%0t singular exp %b got %b", $time, es, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done && angles_q.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (errors == 0 && angles_q.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end
endmodule

// ----- sim.f -----
+incdir+src
src/rmte_pkg.sv
src/rmte_sqrt.sv
src/rmte_cordic.sv
src/rotation_matrix_to_euler_angles.sv
tb/sv/rotation_matrix_to_euler_angles_tb.sv
